// ===== rtl/partitioned_media_list_core_macros.svh =====
// assertion macros for the partitioned media list core
`ifndef PARTITIONED_MEDIA_LIST_CORE_MACROS_SVH
`define PARTITIONED_MEDIA_LIST_CORE_MACROS_SVH

// condition holds in the same cycle as the trigger
`define PML_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define PML_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== rtl/pml_pkg.sv =====
// shared types and codes of the partitioned media list core
package pml_pkg;

    localparam int IDX_W      = 4;
    localparam int TAG_PORT_W = 16;
    localparam int CNT_PORT_W = 5;

    typedef enum logic [2:0] {
        CMD_START          = 3'd0,
        CMD_APPEND         = 3'd1,
        CMD_UPDATE         = 3'd2,
        CMD_REALLOC_FAILED = 3'd3,
        CMD_REALLOC        = 3'd4,
        CMD_RESET          = 3'd5,
        CMD_REQUEUE        = 3'd6,
        CMD_READ           = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_UNAVAIL = 2'd1,
        ST_ERROR  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_APPEND,
        OP_READ,
        OP_SWAP
    } op_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_READ_PAIR,
        SEQ_WRITE_A,
        SEQ_WRITE_B,
        SEQ_READ_TAG,
        SEQ_APPEND,
        SEQ_DONE
    } seq_state_t;

    // memory work planned for one request
    typedef struct packed {
        op_t  op;
        logic swap0_en;
        logic swap1_en;
    } plan_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_status_t;

endpackage

// ===== rtl/pml_tag_mem.sv =====
// tag memory: one write port, two registered read ports
module pml_tag_mem import pml_pkg::*; #(
    parameter int MAX_MEDIA = 16,
    parameter int TAG_BITS  = 16,
    localparam int AW = $clog2(MAX_MEDIA)
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr_a,
    input  logic [AW-1:0]       rd_addr_b,
    output logic [TAG_BITS-1:0] rd_data_a,
    output logic [TAG_BITS-1:0] rd_data_b,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic [TAG_BITS-1:0] wr_data
);

    logic [TAG_BITS-1:0] mem [MAX_MEDIA];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ===== rtl/pml_decode.sv =====
// command decode: checks, counter updates and the memory plan
module pml_decode import pml_pkg::*; #(
    parameter int MAX_MEDIA = 16,
    parameter int TAG_BITS  = 16,
    localparam int CW = $clog2(MAX_MEDIA + 1),
    localparam int AW = $clog2(MAX_MEDIA)
) (
    input  logic [2:0]            cmd,
    input  logic [TAG_PORT_W-1:0] medium_tag,
    input  logic [IDX_W-1:0]      index_a,
    input  logic [IDX_W-1:0]      index_b,
    input  logic [1:0]            status,
    input  logic [CW-1:0]         list_size,
    input  logic [CW-1:0]         alloc_total,
    input  logic [CW-1:0]         avail_total,
    input  logic [CW-1:0]         err_total,
    input  logic                  reset_seen,
    output logic [CW-1:0]         list_size_n,
    output logic [CW-1:0]         alloc_total_n,
    output logic [CW-1:0]         avail_total_n,
    output logic [CW-1:0]         err_total_n,
    output logic                  reset_seen_n,
    output logic                  fault,
    output plan_t                 plan,
    output logic [AW-1:0]         a0,
    output logic [AW-1:0]         b0,
    output logic [AW-1:0]         a1,
    output logic [AW-1:0]         b1,
    output logic [TAG_BITS-1:0]   wr_tag
);

    localparam int XW  = (CW > IDX_W) ? CW : IDX_W;
    localparam int C1W = CW + 1;
    localparam int SW  = CW + 2;

    logic          ia_ok;
    logic          ib_ok;
    logic [CW-1:0] avail_dec;
    logic [CW-1:0] last_usable;
    logic [SW-1:0] sum3;
    logic [C1W-1:0] sum2;
    logic [AW-1:0] ia_addr;
    logic [AW-1:0] ib_addr;

    assign ia_ok       = XW'(index_a) < XW'(list_size);
    assign ib_ok       = XW'(index_b) < XW'(list_size);
    assign avail_dec   = avail_total - CW'(1);
    assign last_usable = list_size - err_total - CW'(1);
    assign sum3        = SW'(avail_total) + SW'(err_total) + SW'(alloc_total);
    assign sum2        = C1W'(err_total) + C1W'(alloc_total);
    assign ia_addr     = AW'(index_a);
    assign ib_addr     = AW'(index_b);
    assign wr_tag      = TAG_BITS'(medium_tag);

    always_comb
    begin
        list_size_n   = list_size;
        alloc_total_n = alloc_total;
        avail_total_n = avail_total;
        err_total_n   = err_total;
        reset_seen_n  = reset_seen;
        fault         = 1'b0;
        plan.op       = OP_NONE;
        plan.swap0_en = 1'b0;
        plan.swap1_en = 1'b0;
        a0            = ia_addr;
        b0            = ia_addr;
        a1            = ia_addr;
        b1            = ia_addr;

        unique case (cmd_t'(cmd))
            CMD_START:
            begin
                avail_total_n = list_size;
                alloc_total_n = '0;
                err_total_n   = '0;
                reset_seen_n  = 1'b0;
            end
            CMD_APPEND:
            begin
                if (C1W'(list_size) >= C1W'(MAX_MEDIA))
                begin
                    fault = 1'b1;
                end
                else
                begin
                    plan.op     = OP_APPEND;
                    a0          = AW'(list_size);
                    list_size_n = list_size + CW'(1);
                end
            end
            CMD_UPDATE:
            begin
                if (!ia_ok)
                begin
                    fault = 1'b1;
                end
                else
                begin
                    case (status_t'(status))
                        ST_OK:
                        begin
                            if (alloc_total >= list_size)
                            begin
                                fault = 1'b1;
                            end
                            else
                            begin
                                plan.swap0_en = 1'b1;
                                b0            = AW'(alloc_total);
                                alloc_total_n = alloc_total + CW'(1);
                            end
                        end
                        ST_UNAVAIL:
                        begin
                            if (avail_total == '0)
                            begin
                                fault = 1'b1;
                            end
                            else
                            begin
                                avail_total_n = avail_dec;
                                plan.swap1_en = XW'(index_a) < XW'(avail_dec);
                                b1            = AW'(avail_dec);
                            end
                        end
                        ST_ERROR:
                        begin
                            if (avail_total == '0 || err_total >= list_size ||
                                (reset_seen && alloc_total == '0))
                            begin
                                fault = 1'b1;
                            end
                            else
                            begin
                                // move to the back of the usable part, then
                                // out of the available section
                                plan.swap0_en = (list_size - err_total) != avail_total;
                                b0            = AW'(last_usable);
                                err_total_n   = err_total + CW'(1);
                                if (reset_seen)
                                begin
                                    alloc_total_n = alloc_total - CW'(1);
                                end
                                avail_total_n = avail_dec;
                                plan.swap1_en = XW'(index_a) < XW'(avail_dec);
                                b1            = AW'(avail_dec);
                            end
                        end
                        default:
                        begin
                            fault = 1'b1;
                        end
                    endcase
                end
            end
            CMD_REALLOC_FAILED:
            begin
                if (!ia_ok || !ib_ok || err_total >= list_size ||
                    avail_total == '0 || sum3 != SW'(list_size))
                begin
                    fault = 1'b1;
                end
                else
                begin
                    plan.swap0_en = 1'b1;
                    plan.swap1_en = 1'b1;
                    b0            = AW'(last_usable);
                    a1            = ib_addr;
                    b1            = AW'(last_usable);
                    err_total_n   = err_total + CW'(1);
                    avail_total_n = avail_dec;
                end
            end
            CMD_REALLOC:
            begin
                if (!ia_ok || !ib_ok)
                begin
                    fault = 1'b1;
                end
                else
                begin
                    plan.swap0_en = 1'b1;
                    b0            = ib_addr;
                end
            end
            CMD_RESET:
            begin
                if (sum2 > C1W'(list_size))
                begin
                    fault = 1'b1;
                end
                else
                begin
                    avail_total_n = list_size - err_total - alloc_total;
                    reset_seen_n  = 1'b1;
                end
            end
            CMD_REQUEUE:
            begin
                if (err_total > list_size)
                begin
                    fault = 1'b1;
                end
                else
                begin
                    avail_total_n = list_size - err_total;
                    alloc_total_n = '0;
                end
            end
            CMD_READ:
            begin
                if (!ia_ok)
                begin
                    fault = 1'b1;
                end
                else
                begin
                    plan.op = OP_READ;
                end
            end
        endcase

        if (plan.swap0_en || plan.swap1_en)
        begin
            plan.op = OP_SWAP;
        end
    end

endmodule

// ===== rtl/pml_seq.sv =====
// memory sequencer: append writes, reads and up to two dependent swaps
module pml_seq import pml_pkg::*; #(
    parameter int MAX_MEDIA = 16,
    parameter int TAG_BITS  = 16,
    localparam int AW = $clog2(MAX_MEDIA)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  plan_t               plan,
    input  logic [AW-1:0]       a0,
    input  logic [AW-1:0]       b0,
    input  logic [AW-1:0]       a1,
    input  logic [AW-1:0]       b1,
    input  logic [TAG_BITS-1:0] wr_tag,
    input  logic                take,
    output seq_status_t         seq_st,
    output logic [TAG_BITS-1:0] rd_tag,
    output logic                mem_rd_en,
    output logic [AW-1:0]       mem_rd_addr_a,
    output logic [AW-1:0]       mem_rd_addr_b,
    input  logic [TAG_BITS-1:0] mem_rd_data_a,
    input  logic [TAG_BITS-1:0] mem_rd_data_b,
    output logic                mem_wr_en,
    output logic [AW-1:0]       mem_wr_addr,
    output logic [TAG_BITS-1:0] mem_wr_data
);

    seq_state_t          state_reg, state_next;
    logic                phase_reg, phase_next;
    op_t                 op_reg;
    logic                swap1_reg;
    logic [AW-1:0]       a0_reg, b0_reg, a1_reg, b1_reg;
    logic [TAG_BITS-1:0] wr_tag_reg;
    logic [TAG_BITS-1:0] hold_reg;
    logic [TAG_BITS-1:0] rd_tag_reg;
    logic [AW-1:0]       cur_a;
    logic [AW-1:0]       cur_b;
    seq_state_t          first_state;

    assign cur_a = phase_reg ? a1_reg : a0_reg;
    assign cur_b = phase_reg ? b1_reg : b0_reg;

    always_comb
    begin
        unique case (plan.op)
            OP_NONE:   first_state = SEQ_DONE;
            OP_APPEND: first_state = SEQ_APPEND;
            OP_READ:   first_state = SEQ_READ_PAIR;
            OP_SWAP:   first_state = SEQ_READ_PAIR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            phase_reg <= 1'b0;
            op_reg    <= OP_NONE;
            swap1_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (start)
            begin
                op_reg    <= plan.op;
                swap1_reg <= plan.swap1_en;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        mem_rd_en     = 1'b0;
        mem_rd_addr_a = cur_a;
        mem_rd_addr_b = cur_b;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = cur_a;
        mem_wr_data   = mem_rd_data_b;

        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                begin
                    state_next = first_state;
                    phase_next = !plan.swap0_en;
                end
            end
            SEQ_READ_PAIR:
            begin
                mem_rd_en  = 1'b1;
                state_next = (op_reg == OP_READ) ? SEQ_READ_TAG : SEQ_WRITE_A;
            end
            SEQ_WRITE_A:
            begin
                mem_wr_en  = 1'b1;
                state_next = SEQ_WRITE_B;
            end
            SEQ_WRITE_B:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = cur_b;
                mem_wr_data = hold_reg;
                // second swap reads only after both writes of the first land
                if (!phase_reg && swap1_reg)
                begin
                    phase_next = 1'b1;
                    state_next = SEQ_READ_PAIR;
                end
                else
                begin
                    state_next = SEQ_DONE;
                end
            end
            SEQ_READ_TAG:
            begin
                state_next = SEQ_DONE;
            end
            SEQ_APPEND:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = a0_reg;
                mem_wr_data = wr_tag_reg;
                state_next  = SEQ_DONE;
            end
            SEQ_DONE:
            begin
                if (take)
                begin
                    if (start)
                    begin
                        state_next = first_state;
                        phase_next = !plan.swap0_en;
                    end
                    else
                    begin
                        state_next = SEQ_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a0_reg     <= a0;
            b0_reg     <= b0;
            a1_reg     <= a1;
            b1_reg     <= b1;
            wr_tag_reg <= wr_tag;
            rd_tag_reg <= '0;
        end
        else if (state_reg == SEQ_READ_TAG)
        begin
            rd_tag_reg <= mem_rd_data_a;
        end
        if (state_reg == SEQ_WRITE_A)
        begin
            hold_reg <= mem_rd_data_a;
        end
    end

    assign rd_tag      = rd_tag_reg;
    assign seq_st.idle = (state_reg == SEQ_IDLE);
    assign seq_st.done = (state_reg == SEQ_DONE);

endmodule

// ===== rtl/partitioned_media_list_core.sv =====
// top level of the partitioned media list core
// a request with no memory work goes straight to done; an append writes its tag, a read issues
// a memory read and then captures the tag, and a swap request does one or two swaps; each swap is
// a read pair plus two writes on the single write port of the tag memory
// the next request is taken in the same cycle as the last result is loaded
// reset clears counters, flags and handshake state; tag slots are undefined until written
`include "partitioned_media_list_core_macros.svh"
module partitioned_media_list_core import pml_pkg::*; #(
    parameter int MAX_MEDIA = 16,
    parameter int TAG_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [2:0]            cmd,
    input  logic [TAG_PORT_W-1:0] medium_tag,
    input  logic [IDX_W-1:0]      index_a,
    input  logic [IDX_W-1:0]      index_b,
    input  logic [1:0]            status,
    // result channel
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic [CNT_PORT_W-1:0] available_count,
    output logic [CNT_PORT_W-1:0] allocated_count,
    output logic [CNT_PORT_W-1:0] error_count,
    output logic [CNT_PORT_W-1:0] usable_count,
    output logic [TAG_PORT_W-1:0] entry_tag,
    output logic                  fault
);

    localparam int CW = $clog2(MAX_MEDIA + 1);
    localparam int AW = $clog2(MAX_MEDIA);

    // section counters
    logic [CW-1:0] list_reg;
    logic [CW-1:0] alloc_reg;
    logic [CW-1:0] avail_reg;
    logic [CW-1:0] err_reg;
    logic          reset_seen_reg;
    logic          fault_reg;

    // decoder outputs
    logic [CW-1:0]       list_next;
    logic [CW-1:0]       alloc_next;
    logic [CW-1:0]       avail_next;
    logic [CW-1:0]       err_next;
    logic                reset_seen_next;
    logic                fault_next;
    plan_t               plan;
    logic [AW-1:0]       a0, b0, a1, b1;
    logic [TAG_BITS-1:0] wr_tag;

    // sequencer and memory
    seq_status_t         seq_st;
    logic [TAG_BITS-1:0] rd_tag;
    logic                mem_rd_en;
    logic [AW-1:0]       mem_rd_addr_a;
    logic [AW-1:0]       mem_rd_addr_b;
    logic [TAG_BITS-1:0] mem_rd_data_a;
    logic [TAG_BITS-1:0] mem_rd_data_b;
    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    logic [TAG_BITS-1:0] mem_wr_data;

    // result register
    logic                  rsp_valid_reg;
    logic [CNT_PORT_W-1:0] avail_out_reg;
    logic [CNT_PORT_W-1:0] alloc_out_reg;
    logic [CNT_PORT_W-1:0] err_out_reg;
    logic [CNT_PORT_W-1:0] usable_out_reg;
    logic [TAG_PORT_W-1:0] tag_out_reg;
    logic                  fault_out_reg;

    logic          take;
    logic          accept;
    logic          load_rsp;
    logic [CW-1:0] usable;

    // result register can take a finished request when empty or draining
    assign take     = !rsp_valid_reg || !rsp_stall;
    assign load_rsp = seq_st.done && take;
    // the next request may enter in the same cycle the finished one moves out
    assign req_stall = !(seq_st.idle || load_rsp);
    assign accept    = req_valid && !req_stall;

    pml_decode #(
        .MAX_MEDIA (MAX_MEDIA),
        .TAG_BITS  (TAG_BITS)
    ) u_decode (
        .cmd           (cmd),
        .medium_tag    (medium_tag),
        .index_a       (index_a),
        .index_b       (index_b),
        .status        (status),
        .list_size     (list_reg),
        .alloc_total   (alloc_reg),
        .avail_total   (avail_reg),
        .err_total     (err_reg),
        .reset_seen    (reset_seen_reg),
        .list_size_n   (list_next),
        .alloc_total_n (alloc_next),
        .avail_total_n (avail_next),
        .err_total_n   (err_next),
        .reset_seen_n  (reset_seen_next),
        .fault         (fault_next),
        .plan          (plan),
        .a0            (a0),
        .b0            (b0),
        .a1            (a1),
        .b1            (b1),
        .wr_tag        (wr_tag)
    );

    pml_seq #(
        .MAX_MEDIA (MAX_MEDIA),
        .TAG_BITS  (TAG_BITS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (accept),
        .plan          (plan),
        .a0            (a0),
        .b0            (b0),
        .a1            (a1),
        .b1            (b1),
        .wr_tag        (wr_tag),
        .take          (take),
        .seq_st        (seq_st),
        .rd_tag        (rd_tag),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr_a (mem_rd_addr_a),
        .mem_rd_addr_b (mem_rd_addr_b),
        .mem_rd_data_a (mem_rd_data_a),
        .mem_rd_data_b (mem_rd_data_b),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data)
    );

    pml_tag_mem #(
        .MAX_MEDIA (MAX_MEDIA),
        .TAG_BITS  (TAG_BITS)
    ) u_tag_mem (
        .clk       (clk),
        .rd_en     (mem_rd_en),
        .rd_addr_a (mem_rd_addr_a),
        .rd_addr_b (mem_rd_addr_b),
        .rd_data_a (mem_rd_data_a),
        .rd_data_b (mem_rd_data_b),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_data   (mem_wr_data)
    );

    // counters move at request time; a rejected request reloads the same values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_reg       <= '0;
            alloc_reg      <= '0;
            avail_reg      <= '0;
            err_reg        <= '0;
            reset_seen_reg <= 1'b0;
            fault_reg      <= 1'b0;
        end
        else if (accept)
        begin
            list_reg       <= list_next;
            alloc_reg      <= alloc_next;
            avail_reg      <= avail_next;
            err_reg        <= err_next;
            reset_seen_reg <= reset_seen_next;
            fault_reg      <= fault_next;
        end
    end

    assign usable = (list_reg >= err_reg) ? (list_reg - err_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (load_rsp)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // counters here still belong to the finished request: a new one that enters
    // at this edge updates them at this same edge, so the old values are captured
    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            avail_out_reg  <= CNT_PORT_W'(avail_reg);
            alloc_out_reg  <= CNT_PORT_W'(alloc_reg);
            err_out_reg    <= CNT_PORT_W'(err_reg);
            usable_out_reg <= CNT_PORT_W'(usable);
            tag_out_reg    <= TAG_PORT_W'(rd_tag);
            fault_out_reg  <= fault_reg;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign available_count = avail_out_reg;
    assign allocated_count = alloc_out_reg;
    assign error_count     = err_out_reg;
    assign usable_count    = usable_out_reg;
    assign entry_tag       = tag_out_reg;
    assign fault           = fault_out_reg;

    // sections never outgrow the list, and the list never outgrows the store
    `PML_ASSERT_NOW(a_sections_fit, 1'b1,
        (alloc_reg <= list_reg) && (err_reg <= list_reg) && (avail_reg <= list_reg),
        "section counter exceeds list size")
    `PML_ASSERT_NOW(a_list_fits, 1'b1, ({1'b0, list_reg} <= (CW + 1)'(MAX_MEDIA)),
        "list size exceeds store depth")
    // a rejected request leaves every counter alone
    `PML_ASSERT_NEXT(a_fault_no_change, accept && fault_next,
        $stable(list_reg) && $stable(alloc_reg) && $stable(avail_reg) && $stable(err_reg)
        && $stable(reset_seen_reg), "rejected request changed state")
    // a result is only produced by a finished sequence
    `PML_ASSERT_NOW(a_rsp_from_done, $rose(rsp_valid_reg), $past(seq_st.done),
        "result loaded without finished request")

endmodule
